// ===== rtl/nnt_pkg.sv =====
// ============================================================================
// nnt_pkg
// Shared widths and default sizes for the nearest-neighbor tour block.
// ============================================================================
package nnt_pkg;

    // Default sizing for the top-level parameters.
    localparam int MAX_CITIES_DEF = 32;
    localparam int DIST_BITS_DEF  = 16;

    // Fixed field widths of the configuration register and the result.
    localparam int CFG_W  = 6;
    localparam int CITY_W = 6;

    // City count after reset.
    localparam logic [CFG_W-1:0] CITY_COUNT_RESET = 6'd32;

endpackage

// ===== rtl/nnt_dist_if.sv =====
// ============================================================================
// nnt_dist_if
// Valid/ready channel that carries one distance matrix entry per request.
// ============================================================================
interface nnt_dist_if #(
    parameter int DIST_BITS = nnt_pkg::DIST_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [DIST_BITS-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

// ===== rtl/nnt_city_if.sv =====
// ============================================================================
// nnt_city_if
// Valid/ready channel that carries one tour city per request.
// ============================================================================
interface nnt_city_if;
    logic                      valid;
    logic                      ready;
    logic [nnt_pkg::CITY_W-1:0] city_number;
    logic                      tour_end;

    modport source (output valid, output city_number, output tour_end, input ready);
    modport sink   (input valid, input city_number, input tour_end, output ready);
endinterface

// ===== rtl/nnt_store.sv =====
// ============================================================================
// nnt_store
// Distance matrix memory: one write port, one read port with registered data.
// ============================================================================
module nnt_store #(
    parameter int DEPTH     = nnt_pkg::MAX_CITIES_DEF * nnt_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS = nnt_pkg::DIST_BITS_DEF,
    parameter int AW        = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [DIST_BITS-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [DIST_BITS-1:0] rd_data
);

    logic [DIST_BITS-1:0] mem [DEPTH];
    logic [DIST_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/nearest_neighbour_tour_top.sv =====
// ============================================================================
// nearest_neighbour_tour_top
// Greedy nearest-neighbor tour over a streamed distance matrix.
//
// The block takes an N by N distance matrix on the matrix channel, one entry
// per request in row-major order (row is the city left, column the city
// reached), with N the city count register clamped to 2..MAX_CITIES. While
// loading it takes one entry every cycle. After the last entry it stops
// taking requests and builds the tour starting at city 1: from the current
// city it moves to the unvisited city with the smallest nonzero distance,
// lowest index on a tie, or to the highest-numbered unvisited city when all
// unvisited candidates are at distance zero. The tour leaves on the tour
// channel as 1-based city numbers, city 1 first, with tour_end set on the
// last one. Each step after the first reads one matrix row through the single
// read port of the distance memory and runs it past one shared comparator.
// The distance memory holds no reset value and needs no clearing pass;
// entries are valid once loaded. The city count is written through
// cfg_wr_en and cfg_wr_data and is meant to change only while the block
// is idle.
// ============================================================================
module nearest_neighbour_tour_top #(
    parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = nnt_pkg::DIST_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [nnt_pkg::CFG_W-1:0] cfg_wr_data,
    nnt_dist_if.sink                  matrix,
    nnt_city_if.source                tour
);

    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_CITIES);
    localparam int CW    = $clog2(MAX_CITIES + 1);
    localparam int SQ_W  = 2 * CW;

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,  // taking matrix entries
        S_FIRST = 6'b000010,  // posting the start city
        S_ROW   = 6'b000100,  // computing the row base of the current city
        S_SCAN  = 6'b001000,  // reading the row, one column per cycle
        S_LAST  = 6'b010000,  // comparing the final column read
        S_PUT   = 6'b100000   // posting the chosen city
    } state_t;

    state_t                     state_reg, state_next;
    logic [nnt_pkg::CFG_W-1:0]  city_count_reg, city_count_next;
    logic [AW-1:0]              load_pos_reg, load_pos_next;
    logic [MAX_CITIES-1:0]      visited_reg, visited_next;
    logic [IW-1:0]              cur_reg, cur_next;
    logic [AW-1:0]              row_base_reg, row_base_next;
    logic [IW-1:0]              scan_idx_reg, scan_idx_next;
    logic                       chk_valid_reg, chk_valid_next;
    logic [IW-1:0]              chk_idx_reg, chk_idx_next;
    logic                       chk_free_reg, chk_free_next;
    logic                       found_reg, found_next;
    logic [IW-1:0]              best_reg, best_next;
    logic [DIST_BITS-1:0]       best_d_reg, best_d_next;
    logic [IW-1:0]              last_free_reg, last_free_next;
    logic [CW-1:0]              step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;
    logic [nnt_pkg::CITY_W-1:0] out_city_reg, out_city_next;
    logic                       out_end_reg, out_end_next;

    logic [CW-1:0]              n_used;
    logic [SQ_W-1:0]            n_sq;
    logic                       load_done;
    logic                       in_take;
    logic                       out_free;
    logic [IW-1:0]              next_city;
    logic [AW-1:0]              rd_addr;
    logic [DIST_BITS-1:0]       rd_data;

    // The count register is clamped into the supported range of cities.
    always_comb
    begin
        if (int'(city_count_reg) < 2)
        begin
            n_used = CW'(2);
        end
        else if (int'(city_count_reg) > MAX_CITIES)
        begin
            n_used = CW'(MAX_CITIES);
        end
        else
        begin
            n_used = CW'(city_count_reg);
        end
    end

    // The load ends on the entry at or past the last one for the count in force.
    assign n_sq      = SQ_W'(n_used) * SQ_W'(n_used);
    assign load_done = (SQ_W'(load_pos_reg) >= (n_sq - SQ_W'(1)));

    assign matrix.ready = (state_reg == S_LOAD);
    assign in_take      = matrix.valid && matrix.ready;

    // The output register is free when empty or when its request leaves now.
    assign out_free = !out_valid_reg || tour.ready;

    // A city with a nonzero distance wins; otherwise the last free city seen.
    assign next_city = found_reg ? best_reg : last_free_reg;

    assign rd_addr = row_base_reg + AW'(scan_idx_reg);

    nnt_store #(
        .DEPTH     (DEPTH),
        .DIST_BITS (DIST_BITS),
        .AW        (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_take),
        .wr_addr (load_pos_reg),
        .wr_data (matrix.distance),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        city_count_next = city_count_reg;
        load_pos_next   = load_pos_reg;
        visited_next    = visited_reg;
        cur_next        = cur_reg;
        row_base_next   = row_base_reg;
        scan_idx_next   = scan_idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        chk_free_next   = chk_free_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_d_next     = best_d_reg;
        last_free_next  = last_free_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !tour.ready;
        out_city_next   = out_city_reg;
        out_end_next    = out_end_reg;

        if (cfg_wr_en)
        begin
            city_count_next = cfg_wr_data;
        end

        // Shared comparator: one column of the current row per cycle.
        if (chk_valid_reg && chk_free_reg)
        begin
            last_free_next = chk_idx_reg;
            if ((rd_data != '0) && (!found_reg || (rd_data < best_d_reg)))
            begin
                found_next  = 1'b1;
                best_next   = chk_idx_reg;
                best_d_next = rd_data;
            end
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_take)
                begin
                    if (load_done)
                    begin
                        load_pos_next = '0;
                        state_next    = S_FIRST;
                    end
                    else
                    begin
                        load_pos_next = load_pos_reg + AW'(1);
                    end
                end
            end

            S_FIRST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_city_next  = nnt_pkg::CITY_W'(1);
                    out_end_next   = 1'b0;
                    visited_next   = MAX_CITIES'(1);
                    cur_next       = '0;
                    step_next      = CW'(1);
                    state_next     = S_ROW;
                end
            end

            S_ROW:
            begin
                row_base_next = AW'(AW'(cur_reg) * AW'(n_used));
                scan_idx_next = '0;
                found_next    = 1'b0;
                state_next    = S_SCAN;
            end

            S_SCAN:
            begin
                chk_valid_next = 1'b1;
                chk_idx_next   = scan_idx_reg;
                chk_free_next  = !visited_reg[scan_idx_reg];
                if (CW'(scan_idx_reg) == (n_used - CW'(1)))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
            end

            S_LAST:
            begin
                state_next = S_PUT;
            end

            S_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_city_next           = nnt_pkg::CITY_W'(next_city) +
                                              nnt_pkg::CITY_W'(1);
                    out_end_next            = (step_reg == (n_used - CW'(1)));
                    visited_next[next_city] = 1'b1;
                    cur_next                = next_city;
                    step_next               = step_reg + CW'(1);
                    if (step_reg == (n_used - CW'(1)))
                    begin
                        visited_next = MAX_CITIES'(1);
                        cur_next     = '0;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_ROW;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            city_count_reg <= nnt_pkg::CITY_COUNT_RESET;
            load_pos_reg   <= '0;
            visited_reg    <= MAX_CITIES'(1);
            cur_reg        <= '0;
            scan_idx_reg   <= '0;
            step_reg       <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            city_count_reg <= city_count_next;
            load_pos_reg   <= load_pos_next;
            visited_reg    <= visited_next;
            cur_reg        <= cur_next;
            scan_idx_reg   <= scan_idx_next;
            step_reg       <= step_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        row_base_reg  <= row_base_next;
        chk_idx_reg   <= chk_idx_next;
        chk_free_reg  <= chk_free_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        best_d_reg    <= best_d_next;
        last_free_reg <= last_free_next;
        out_city_reg  <= out_city_next;
        out_end_reg   <= out_end_next;
    end

    assign tour.valid       = out_valid_reg;
    assign tour.city_number = out_city_reg;
    assign tour.tour_end    = out_end_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the nearest-neighbor tour block. Distance matrices
// are streamed in on the matrix channel. A local model rebuilds every greedy
// tour; each city request on the tour channel is checked in order against it or
// a directed row's shape. Random gaps and stalls are applied on both channels.
// ============================================================================
module tb;

    localparam int MAX_CITIES   = nnt_pkg::MAX_CITIES_DEF;
    localparam int DIST_BITS    = nnt_pkg::DIST_BITS_DEF;
    localparam int CFG_W        = nnt_pkg::CFG_W;
    localparam int CITY_W       = nnt_pkg::CITY_W;
    localparam int STORE_DEPTH  = MAX_CITIES * MAX_CITIES;
    localparam int CASE_COUNT   = 10;
    localparam int RANDOM_ITEMS = 200;
    // Quiet cycles after the last city before the count register is touched.
    localparam int IDLE_GUARD   = 64;
    localparam int CYCLE_LIMIT  = 600000;

    // How a directed matrix is filled.
    typedef enum logic [2:0] {
        FILL_ZERO,
        FILL_MAX,
        FILL_RING,
        FILL_CHECKER,
        FILL_RANDOM
    } fill_t;

    // Where the expected tour of a matrix comes from.
    typedef enum logic [1:0] {
        TOUR_PREDICTED,
        TOUR_ASCENDING,
        TOUR_DESCENDING
    } shape_t;

    typedef struct packed {
        logic             load_count;
        logic [CFG_W-1:0] count_value;
        fill_t            fill;
        shape_t           shape;
        logic [9:0]       shrink_after;
        logic [CFG_W-1:0] shrink_value;
    } matrix_case_t;

    typedef struct packed {
        logic [CITY_W-1:0] city_number;
        logic              tour_end;
    } tour_stop_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    nnt_dist_if #(.DIST_BITS(DIST_BITS)) matrix_ch ();
    nnt_city_if                          tour_ch ();

    nearest_neighbour_tour_top #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .matrix      (matrix_ch),
        .tour        (tour_ch)
    );

    // Bench state. The model keeps its own copy of the distance memory, the
    // load position and the city count register.
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    int                  stall_left     = 0;
    bit                  steady_run     = 1'b0;
    logic [DIST_BITS-1:0] dist_copy [STORE_DEPTH];
    logic [9:0]          load_pos   = '0;
    logic [CFG_W-1:0]    count_copy = nnt_pkg::CITY_COUNT_RESET;
    logic [CITY_W-1:0]   route_plan [MAX_CITIES];
    int                  route_len  = 0;
    tour_stop_t          expected_stops [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The directed table. Rows whose tour has an obvious shape carry that
    // shape; the rest are checked against the model. A nonzero shrink_after
    // rewrites the count to a smaller value after that many entries.
    function automatic matrix_case_t matrix_case(input int idx);
        case (idx)
            // Count out of reset, cut to six cities once the load is past the
            // six-city matrix; all zero, so every step falls back to the
            // highest unvisited city.
            0: return '{1'b0, 6'd0,  FILL_ZERO,    TOUR_DESCENDING, 10'd40, 6'd6};
            // Counts below two are used as two.
            1: return '{1'b1, 6'd0,  FILL_MAX,     TOUR_ASCENDING,  10'd0,  6'd0};
            2: return '{1'b1, 6'd1,  FILL_ZERO,    TOUR_DESCENDING, 10'd0,  6'd0};
            3: return '{1'b1, 6'd2,  FILL_CHECKER, TOUR_PREDICTED,  10'd0,  6'd0};
            // All distances equal: ties go to the lowest index.
            4: return '{1'b1, 6'd3,  FILL_MAX,     TOUR_ASCENDING,  10'd0,  6'd0};
            // A cheap edge back to the previous city walks the ring downward.
            5: return '{1'b1, 6'd4,  FILL_RING,    TOUR_DESCENDING, 10'd0,  6'd0};
            // A count above the maximum keeps the load open until it is cut.
            6: return '{1'b1, 6'd63, FILL_MAX,     TOUR_ASCENDING,  10'd40, 6'd6};
            // Shrink mid-load before the new last entry is reached.
            7: return '{1'b1, 6'd5,  FILL_RANDOM,  TOUR_PREDICTED,  10'd4,  6'd3};
            // Shrink mid-load after the new last entry has been passed.
            8: return '{1'b1, 6'd4,  FILL_RANDOM,  TOUR_PREDICTED,  10'd12, 6'd3};
            9: return '{1'b1, 6'd3,  FILL_CHECKER, TOUR_PREDICTED,  10'd6,  6'd1};
            default: return '0;
        endcase
    endfunction

    // Most gaps are short, a few are long, and steady stretches have none.
    function automatic int pick_gap();
        int r;
        if (steady_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random distances lean on zeros, small ties and the top value.
    function automatic logic [DIST_BITS-1:0] random_distance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        if (r < 35)
            return DIST_BITS'($urandom_range(1, 3));
        if (r < 42)
            return '1;
        return DIST_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic logic [DIST_BITS-1:0] fill_value(input fill_t fill, input int k,
                                                       input int n);
        int row;
        int col;
        row = k / n;
        col = k % n;
        case (fill)
            FILL_ZERO:    return '0;
            FILL_MAX:     return '1;
            FILL_RING:    return (col == (row + n - 1) % n) ? DIST_BITS'(1) : '1;
            FILL_CHECKER: return k[0] ? DIST_BITS'(16'h5555) : DIST_BITS'(16'hAAAA);
            default:      return random_distance();
        endcase
    endfunction

    function automatic int city_limit();
        if (count_copy < 2)
            return 2;
        if (count_copy > MAX_CITIES)
            return MAX_CITIES;
        return count_copy;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Stores one entry into the model. On the last entry of the matrix the
    // greedy tour is built into route_plan and complete is set.
    task automatic absorb_entry(input logic [DIST_BITS-1:0] value, output bit complete);
        int                   n;
        int                   last_pos;
        int                   step;
        int                   c;
        int                   here;
        int                   best;
        int                   last_free;
        bit                   found;
        logic [DIST_BITS-1:0] d;
        logic [DIST_BITS-1:0] best_d;
        logic [MAX_CITIES-1:0] visited;
        n = city_limit();
        last_pos = n * n - 1;
        dist_copy[load_pos] = value;
        complete = 1'b0;
        if (load_pos < last_pos)
        begin
            load_pos = load_pos + 1'b1;
        end
        else
        begin
            visited = 1;
            here = 0;
            route_plan[0] = CITY_W'(1);
            for (step = 1; step < n; step++)
            begin
                found = 1'b0;
                best = 0;
                best_d = '0;
                last_free = 0;
                for (c = 0; c < n; c++)
                begin
                    if (!visited[c])
                    begin
                        last_free = c;
                        d = dist_copy[here * n + c];
                        if (d != 0 && (!found || d < best_d))
                        begin
                            found = 1'b1;
                            best = c;
                            best_d = d;
                        end
                    end
                end
                here = found ? best : last_free;
                visited[here] = 1'b1;
                route_plan[step] = CITY_W'(here + 1);
            end
            route_len = n;
            load_pos = '0;
            complete = 1'b1;
        end
    endtask

    // Writes the count register. The write lands on the edge that ends the
    // task, and the model takes the new count at the same point.
    task automatic write_count(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        count_copy = value;
    endtask

    // Presents one entry and returns on the edge where the request is taken.
    // Valid stays high on return so that a back-to-back request needs no
    // second assignment in the same step.
    task automatic send_entry(input logic [DIST_BITS-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            matrix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        matrix_ch.valid    <= 1'b1;
        matrix_ch.distance <= value;
        @(posedge clk);
        while (!matrix_ch.ready)
            @(posedge clk);
    endtask

    // Waits until every expected city has arrived, then a quiet stretch so
    // that the block is surely idle before the count register changes.
    task automatic settle_tour();
        matrix_ch.valid <= 1'b0;
        while (expected_stops.size() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    // Streams one matrix until the model says the load is complete, then
    // queues the tour that it must produce.
    task automatic load_matrix(input fill_t fill, input shape_t shape, input int shrink_after,
                               input logic [CFG_W-1:0] shrink_value, output int sent);
        int                   n0;
        int                   i;
        bit                   complete;
        logic [DIST_BITS-1:0] value;
        tour_stop_t           stop;
        n0 = city_limit();
        sent = 0;
        complete = 1'b0;
        while (!complete)
        begin
            if (shrink_after != 0 && sent == shrink_after)
            begin
                matrix_ch.valid <= 1'b0;
                @(posedge clk);
                write_count(shrink_value);
            end
            value = fill_value(fill, sent, n0);
            send_entry(value);
            absorb_entry(value, complete);
            sent++;
        end
        for (i = 0; i < route_len; i++)
        begin
            case (shape)
                TOUR_ASCENDING:  stop.city_number = CITY_W'(i + 1);
                TOUR_DESCENDING: stop.city_number = CITY_W'((i == 0) ? 1 : route_len + 1 - i);
                default:         stop.city_number = route_plan[i];
            endcase
            stop.tour_end = (i == route_len - 1);
            expected_stops.push_back(stop);
        end
    endtask

    // Tour sink: checks every accepted city request against the oldest
    // expectation and drives ready with random stalls.
    always @(posedge clk)
    begin : tour_sink
        tour_stop_t want;
        int         gap;
        if (rst_n && tour_ch.valid && tour_ch.ready)
        begin
            if (expected_stops.size() == 0)
            begin
                report_mismatch($sformatf("unexpected city %0d tour_end %0b",
                                          tour_ch.city_number, tour_ch.tour_end));
            end
            else
            begin
                want = expected_stops.pop_front();
                if (tour_ch.city_number !== want.city_number)
                    report_mismatch($sformatf("city_number got %0d expected %0d",
                                              tour_ch.city_number, want.city_number));
                if (tour_ch.tour_end !== want.tour_end)
                    report_mismatch($sformatf("tour_end got %0b expected %0b at city %0d",
                                              tour_ch.tour_end, want.tour_end,
                                              want.city_number));
            end
        end
        if (!rst_n)
        begin
            tour_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            tour_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                tour_ch.ready <= 1'b0;
                stall_left = gap - 1;
            end
            else
            begin
                tour_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake or a missing city ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus: directed table first, then many small random matrices with
    // occasional count changes.
    initial
    begin
        int               row;
        int               sent;
        int               random_items;
        int               n;
        int               shrink_at;
        int               r;
        logic [CFG_W-1:0] next_count;
        logic [CFG_W-1:0] shrink_to;
        matrix_case_t     mc;

        matrix_ch.valid    <= 1'b0;
        matrix_ch.distance <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < CASE_COUNT; row++)
        begin
            mc = matrix_case(row);
            if (mc.load_count)
            begin
                settle_tour();
                write_count(mc.count_value);
            end
            // One row runs with both channels at full rate.
            steady_run = (row == 4);
            load_matrix(mc.fill, mc.shape, mc.shrink_after, mc.shrink_value, sent);
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            steady_run = ($urandom_range(0, 99) < 15);
            shrink_at = 0;
            shrink_to = '0;
            if ($urandom_range(0, 99) < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    next_count = CFG_W'($urandom_range(0, 1));
                else if (r < 18)
                    next_count = CFG_W'($urandom_range(8, 12));
                else
                    next_count = CFG_W'($urandom_range(2, 7));
                settle_tour();
                write_count(next_count);
            end
            n = city_limit();
            // Now and then the count shrinks while a matrix is half loaded.
            if (n >= 3 && $urandom_range(0, 99) < 12)
            begin
                settle_tour();
                shrink_at = $urandom_range(1, n * n - 1);
                shrink_to = CFG_W'($urandom_range(0, n - 1));
            end
            load_matrix(FILL_RANDOM, TOUR_PREDICTED, shrink_at, shrink_to, sent);
            random_items += sent;
        end

        steady_run = 1'b0;
        settle_tour();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
